FILE: design/sbe_pkg.sv
// Package with opcodes, status codes and shared types of the stack bytecode executor.
`default_nettype none
package sbe_pkg;

  localparam logic [7:0] OP_PUSH  = 8'h01;
  localparam logic [7:0] OP_POP   = 8'h02;
  localparam logic [7:0] OP_DUP   = 8'h03;
  localparam logic [7:0] OP_ADD   = 8'h10;
  localparam logic [7:0] OP_SUB   = 8'h11;
  localparam logic [7:0] OP_MUL   = 8'h12;
  localparam logic [7:0] OP_DIV   = 8'h13;
  localparam logic [7:0] OP_EQ    = 8'h14;
  localparam logic [7:0] OP_NEQ   = 8'h15;
  localparam logic [7:0] OP_LT    = 8'h16;
  localparam logic [7:0] OP_GT    = 8'h17;
  localparam logic [7:0] OP_LE    = 8'h18;
  localparam logic [7:0] OP_GE    = 8'h19;
  localparam logic [7:0] OP_JMP   = 8'h20;
  localparam logic [7:0] OP_JZ    = 8'h21;
  localparam logic [7:0] OP_JNZ   = 8'h22;
  localparam logic [7:0] OP_STORE = 8'h30;
  localparam logic [7:0] OP_LOAD  = 8'h31;
  localparam logic [7:0] OP_CALL  = 8'h40;
  localparam logic [7:0] OP_RET   = 8'h41;
  localparam logic [7:0] OP_HALT  = 8'hFF;

  localparam logic [2:0] ST_RUN   = 3'd0;
  localparam logic [2:0] ST_HALT  = 3'd1;
  localparam logic [2:0] ST_DIVZ  = 3'd2;
  localparam logic [2:0] ST_JUMP  = 3'd3;
  localparam logic [2:0] ST_INDEX = 3'd4;
  localparam logic [2:0] ST_OPC   = 3'd5;
  localparam logic [2:0] ST_UNDER = 3'd6;
  localparam logic [2:0] ST_OVER  = 3'd7;

  localparam logic CFG_LENGTH = 1'b0;
  localparam logic CFG_START  = 1'b1;

  // Handshake between the sequencer and the divider.
  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
  } div_rsp_t;

endpackage
`default_nettype wire

FILE: design/sbe_divider.sv
// Radix-2 restoring divider with truncating signed result, one bit a cycle.
`default_nettype none
module sbe_divider (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  sbe_pkg::div_req_t req_i,
  output sbe_pkg::div_rsp_t rsp_o
);

  logic [31:0] rem_q, rem_d, quo_q, quo_d, dsr_q, dsr_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, neg_q, neg_d, done_q, done_d;
  logic [32:0] trial;
  logic [31:0] rem_sh;

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    neg_d  = neg_q;
    done_d = 1'b0;
    rem_sh = {rem_q[30:0], quo_q[31]};
    trial  = {1'b0, rem_sh} - {1'b0, dsr_q};
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = 6'd0;
      rem_d  = 32'd0;
      quo_d  = req_i.dividend[31] ? 32'd0 - req_i.dividend : req_i.dividend;
      dsr_d  = req_i.divisor[31] ? 32'd0 - req_i.divisor : req_i.divisor;
      neg_d  = req_i.dividend[31] ^ req_i.divisor[31];
    end else if (busy_q) begin
      if (trial[32]) begin
        rem_d = rem_sh;
        quo_d = {quo_q[30:0], 1'b0};
      end else begin
        rem_d = trial[31:0];
        quo_d = {quo_q[30:0], 1'b1};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 6'd0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
    neg_q <= neg_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = neg_q ? 32'd0 - quo_q : quo_q;

endmodule
`default_nettype wire

FILE: design/stack_bytecode_executor.sv
// Top level of the stack bytecode executor: sequencer, stacks, word memory and ALU.
`default_nettype none
// Channel   Direction  Signals
// in        input      in_valid_i, in_ready_o, opcode_i, operand_i
// out       output     out_valid_o, out_ready_i, next_address_o, top_value_o, depth_o,
//                      executed_count_o, status_o
// cfg       input      cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i
//
// An instruction passes accept, operand read, execute and result word, as the stacks
// and the word memory have registered reads; a division also waits in S_DIV for the
// bit-serial divider. Once stopped or at the code end, an accepted instruction goes
// straight to the result word. Reset clears the pointers, the count and the stop
// flag; the word memory then gets a clearing pass over all MEMORY_WORDS words, during
// which no instruction is accepted. A held result word blocks the next one until taken.
module stack_bytecode_executor #(
  parameter int DATA_STACK_DEPTH   = 256,
  parameter int RETURN_STACK_DEPTH = 64,
  parameter int MEMORY_WORDS       = 256,
  parameter int CODE_BYTES_MAX     = 65536
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  wire  [7:0]  opcode_i,
  input  wire  signed [31:0] operand_i,
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output logic [16:0] next_address_o,
  output logic signed [31:0] top_value_o,
  output logic [8:0]  depth_o,
  output logic [31:0] executed_count_o,
  output logic [2:0]  status_o,
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire         cfg_index_i,
  input  wire  [16:0] cfg_data_i
);

  localparam int DW = $clog2(DATA_STACK_DEPTH);
  localparam int RW = $clog2(RETURN_STACK_DEPTH);
  localparam int MW = (MEMORY_WORDS > 1) ? $clog2(MEMORY_WORDS) : 1;
  localparam logic [8:0]  DS_FULL = 9'(DATA_STACK_DEPTH);
  localparam logic [10:0] RS_FULL = 11'(RETURN_STACK_DEPTH);
  localparam logic [24:0] CODE_MAX = 25'(CODE_BYTES_MAX);

  typedef enum logic [5:0] {
    S_CLR  = 6'b000001,
    S_IDLE = 6'b000010,
    S_READ = 6'b000100,
    S_EXEC = 6'b001000,
    S_DIV  = 6'b010000,
    S_OUT  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // Memories.
  logic [31:0] dstk [DATA_STACK_DEPTH];
  logic [16:0] rstk [RETURN_STACK_DEPTH];
  logic [31:0] wmem [MEMORY_WORDS];
  logic [31:0] dtop_q, dsec_q, wrd_q;
  logic [16:0] rrd_q;

  logic [8:0]  sp_q;
  logic [10:0] rp_q;
  logic [16:0] pc_q, len_q;
  logic [15:0] start_q;
  logic [31:0] cnt_q;
  logic        stop_q, begun_q;
  logic [2:0]  hst_q;
  logic [7:0]  op_q;
  logic [31:0] imm_q;
  logic [MW:0] clr_q;
  logic [31:0] top_q;

  // Result word.
  logic [16:0] o_pc_q;
  logic [31:0] o_top_q;
  logic [8:0]  o_sp_q;
  logic [31:0] o_cnt_q;
  logic [2:0]  o_st_q;

  sbe_pkg::div_req_t dreq;
  sbe_pkg::div_rsp_t drsp;

  sbe_divider u_div (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(dreq), .rsp_o(drsp));

  // Effective code end.
  logic [16:0] code_end;
  assign code_end = ({8'd0, len_q} > CODE_MAX) ? CODE_MAX[16:0] : len_q;

  logic target_ok, index_ok, long_op;
  assign target_ok = !imm_q[31] && ({1'b0, imm_q} < {16'd0, code_end});
  assign index_ok  = !imm_q[31] && ({1'b0, imm_q} < 33'(MEMORY_WORDS));
  always_comb begin
    case (op_q)
      sbe_pkg::OP_PUSH, sbe_pkg::OP_JMP, sbe_pkg::OP_JZ, sbe_pkg::OP_JNZ,
      sbe_pkg::OP_STORE, sbe_pkg::OP_LOAD, sbe_pkg::OP_CALL: long_op = 1'b1;
      default: long_op = 1'b0;
    endcase
  end

  // Execute decisions (state S_EXEC, or S_DIV on divider completion).
  logic [2:0]  ex_st;
  logic [8:0]  ex_sp;
  logic [10:0] ex_rp;
  logic [16:0] ex_pc;
  logic [31:0] ex_r, ex_top;
  logic        ds_we, rs_we, wm_we, go_div;
  logic [8:0]  ds_wa;
  logic [31:0] ds_wd;
  logic        take;
  logic signed [31:0] sa, sb;

  always_comb begin
    sa     = signed'(dsec_q);
    sb     = signed'(dtop_q);
    ex_st  = sbe_pkg::ST_RUN;
    ex_sp  = sp_q;
    ex_rp  = rp_q;
    ex_pc  = pc_q + (long_op ? 17'd5 : 17'd1);
    ex_r   = 32'd0;
    ex_top = top_q;
    ds_we  = 1'b0;
    rs_we  = 1'b0;
    wm_we  = 1'b0;
    go_div = 1'b0;
    ds_wa  = sp_q;
    ds_wd  = imm_q;
    take   = 1'b0;
    case (op_q)
      sbe_pkg::OP_PUSH: begin
        if (sp_q >= DS_FULL) ex_st = sbe_pkg::ST_OVER;
        else begin
          ds_we = 1'b1; ex_sp = sp_q + 9'd1; ex_top = imm_q;
        end
      end
      sbe_pkg::OP_POP: begin
        if (sp_q < 9'd1) ex_st = sbe_pkg::ST_UNDER;
        else begin
          ex_sp = sp_q - 9'd1; ex_top = (sp_q > 9'd1) ? dsec_q : 32'd0;
        end
      end
      sbe_pkg::OP_DUP: begin
        if (sp_q < 9'd1) ex_st = sbe_pkg::ST_UNDER;
        else if (sp_q >= DS_FULL) ex_st = sbe_pkg::ST_OVER;
        else begin
          ds_we = 1'b1; ds_wd = dtop_q; ex_sp = sp_q + 9'd1;
        end
      end
      sbe_pkg::OP_ADD, sbe_pkg::OP_SUB, sbe_pkg::OP_MUL, sbe_pkg::OP_DIV,
      sbe_pkg::OP_EQ, sbe_pkg::OP_NEQ, sbe_pkg::OP_LT, sbe_pkg::OP_GT,
      sbe_pkg::OP_LE, sbe_pkg::OP_GE: begin
        if (sp_q < 9'd2) ex_st = sbe_pkg::ST_UNDER;
        else if (op_q == sbe_pkg::OP_DIV && dtop_q == 32'd0) ex_st = sbe_pkg::ST_DIVZ;
        else begin
          case (op_q)
            sbe_pkg::OP_ADD: ex_r = dsec_q + dtop_q;
            sbe_pkg::OP_SUB: ex_r = dsec_q - dtop_q;
            sbe_pkg::OP_MUL: ex_r = dsec_q * dtop_q;
            sbe_pkg::OP_DIV: ex_r = drsp.quotient;
            sbe_pkg::OP_EQ:  ex_r = {31'd0, sa == sb};
            sbe_pkg::OP_NEQ: ex_r = {31'd0, sa != sb};
            sbe_pkg::OP_LT:  ex_r = {31'd0, sa < sb};
            sbe_pkg::OP_GT:  ex_r = {31'd0, sa > sb};
            sbe_pkg::OP_LE:  ex_r = {31'd0, sa <= sb};
            default:         ex_r = {31'd0, sa >= sb};
          endcase
          go_div = (op_q == sbe_pkg::OP_DIV) && (state_q == S_EXEC);
          ds_we = 1'b1; ds_wa = sp_q - 9'd2; ds_wd = ex_r;
          ex_sp = sp_q - 9'd1; ex_top = ex_r;
        end
      end
      sbe_pkg::OP_JMP: begin
        if (!target_ok) ex_st = sbe_pkg::ST_JUMP;
        else ex_pc = imm_q[16:0];
      end
      sbe_pkg::OP_JZ, sbe_pkg::OP_JNZ: begin
        take = (op_q == sbe_pkg::OP_JZ) ? (dtop_q == 32'd0) : (dtop_q != 32'd0);
        if (sp_q < 9'd1) ex_st = sbe_pkg::ST_UNDER;
        else if (take && !target_ok) ex_st = sbe_pkg::ST_JUMP;
        else begin
          ex_sp = sp_q - 9'd1; ex_top = (sp_q > 9'd1) ? dsec_q : 32'd0;
          if (take) ex_pc = imm_q[16:0];
        end
      end
      sbe_pkg::OP_STORE: begin
        if (sp_q < 9'd1) ex_st = sbe_pkg::ST_UNDER;
        else if (!index_ok) ex_st = sbe_pkg::ST_INDEX;
        else begin
          wm_we = 1'b1; ex_sp = sp_q - 9'd1; ex_top = (sp_q > 9'd1) ? dsec_q : 32'd0;
        end
      end
      sbe_pkg::OP_LOAD: begin
        if (!index_ok) ex_st = sbe_pkg::ST_INDEX;
        else if (sp_q >= DS_FULL) ex_st = sbe_pkg::ST_OVER;
        else begin
          ds_we = 1'b1; ds_wd = wrd_q; ex_sp = sp_q + 9'd1; ex_top = wrd_q;
        end
      end
      sbe_pkg::OP_CALL: begin
        if (!target_ok) ex_st = sbe_pkg::ST_JUMP;
        else if (rp_q >= RS_FULL) ex_st = sbe_pkg::ST_OVER;
        else begin
          rs_we = 1'b1; ex_rp = rp_q + 11'd1; ex_pc = imm_q[16:0];
        end
      end
      sbe_pkg::OP_RET: begin
        if (rp_q < 11'd1) ex_st = sbe_pkg::ST_UNDER;
        else begin
          ex_rp = rp_q - 11'd1; ex_pc = rrd_q;
        end
      end
      sbe_pkg::OP_HALT: ex_st = sbe_pkg::ST_HALT;
      default:          ex_st = sbe_pkg::ST_OPC;
    endcase
    if (ex_st != sbe_pkg::ST_RUN) begin
      ds_we = 1'b0; rs_we = 1'b0; wm_we = 1'b0; go_div = 1'b0;
      ex_sp = sp_q; ex_rp = rp_q; ex_top = top_q;
    end else if (ex_pc >= code_end) begin
      ex_st = sbe_pkg::ST_HALT;
    end
  end

  // The divide path commits only when the divider reports completion.
  logic commit;
  assign commit = (state_q == S_EXEC && !go_div) || (state_q == S_DIV && drsp.done);

  assign dreq.start    = (state_q == S_EXEC) && go_div;
  assign dreq.dividend = dsec_q;
  assign dreq.divisor  = dtop_q;

  logic in_acc, cfg_acc, out_acc;
  assign in_ready_o  = (state_q == S_IDLE) && !out_valid_o;
  assign cfg_ready_o = 1'b1;
  assign in_acc  = in_valid_i && in_ready_o;
  assign cfg_acc = cfg_valid_i;
  assign out_acc = out_valid_o && out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLR:  if (clr_q == (MW+1)'(MEMORY_WORDS - 1)) state_d = S_IDLE;
      S_IDLE: begin
        if (in_acc) begin
          state_d = (stop_q || pc_q >= code_end) ? S_OUT : S_READ;
        end
      end
      S_READ: state_d = S_EXEC;
      S_EXEC: state_d = go_div ? S_DIV : S_OUT;
      S_DIV:  if (drsp.done) state_d = S_OUT;
      S_OUT:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Memory ports: reads issued in S_READ, writes on commit or in the clearing pass.
  always_ff @(posedge clk_i) begin
    if (state_q == S_READ) begin
      dtop_q <= dstk[DW'(sp_q - 9'd1)];
      dsec_q <= dstk[DW'(sp_q - 9'd2)];
      wrd_q  <= wmem[MW'(imm_q)];
      rrd_q  <= rstk[RW'(rp_q - 11'd1)];
    end
    if (commit && ds_we) dstk[DW'(ds_wa)] <= ds_wd;
    if (commit && rs_we) rstk[RW'(rp_q)] <= pc_q + 17'd5;
    if (state_q == S_CLR) wmem[MW'(clr_q)] <= 32'd0;
    else if (commit && wm_we) wmem[MW'(imm_q)] <= dtop_q;
    if (in_acc) begin
      op_q  <= opcode_i;
      imm_q <= operand_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      clr_q   <= '0;
      sp_q    <= 9'd0;
      rp_q    <= 11'd0;
      pc_q    <= 17'd0;
      len_q   <= 17'd65536;
      start_q <= 16'd0;
      cnt_q   <= 32'd0;
      stop_q  <= 1'b0;
      begun_q <= 1'b0;
      hst_q   <= sbe_pkg::ST_RUN;
      top_q   <= 32'd0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLR) clr_q <= clr_q + (MW+1)'(1);
      if (cfg_acc) begin
        if (cfg_index_i == sbe_pkg::CFG_LENGTH) len_q <= cfg_data_i;
        else begin
          start_q <= cfg_data_i[15:0];
          if (!begun_q) pc_q <= {1'b0, cfg_data_i[15:0]};
        end
      end
      if (in_acc) begin
        begun_q <= 1'b1;
        if (!stop_q && pc_q >= code_end) begin
          stop_q <= 1'b1;
          hst_q  <= sbe_pkg::ST_HALT;
        end
      end
      if (commit) begin
        sp_q  <= ex_sp;
        rp_q  <= ex_rp;
        pc_q  <= ex_pc;
        top_q <= ex_top;
        cnt_q <= cnt_q + 32'd1;
        if (ex_st != sbe_pkg::ST_RUN) begin
          stop_q <= 1'b1;
          hst_q  <= ex_st;
        end
      end
      if (state_q == S_OUT) out_valid_o <= 1'b1;
      else if (out_acc) out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_OUT) begin
      o_pc_q  <= pc_q;
      o_top_q <= top_q;
      o_sp_q  <= sp_q;
      o_cnt_q <= cnt_q;
      o_st_q  <= stop_q ? hst_q : sbe_pkg::ST_RUN;
    end
  end

  assign next_address_o   = o_pc_q;
  assign top_value_o      = signed'(o_top_q);
  assign depth_o          = o_sp_q;
  assign executed_count_o = o_cnt_q;
  assign status_o         = o_st_q;

endmodule
`default_nettype wire
